### rtl/plucked_string_synth_voice_unit_defines.svh
// ---------------------------------------------------------------------------
// Plucked string voice assertion macros
// Shared property shorthands for the voice RTL.
// ---------------------------------------------------------------------------
`ifndef PLUCKED_STRING_SYNTH_VOICE_UNIT_DEFINES_SVH
`define PLUCKED_STRING_SYNTH_VOICE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PLSV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plsv assertion failed");

// Next-cycle implication, checked out of reset.
`define PLSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plsv assertion failed");

`endif

### rtl/plsv_pkg.sv
// ---------------------------------------------------------------------------
// Plucked string voice package
// Types and fixed constants shared by the voice RTL.
// ---------------------------------------------------------------------------
package plsv_pkg;

  // Item function codes
  localparam logic [1:0] FUNC_TICK       = 2'd0;
  localparam logic [1:0] FUNC_NOTE_ON    = 2'd1;
  localparam logic [1:0] FUNC_NOTE_OFF   = 2'd2;
  localparam logic [1:0] FUNC_SET_PERIOD = 2'd3;

  localparam logic [31:0] LFSR_SEED = 32'hACE1_ACE1;
  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

  localparam logic [15:0] GAIN_RESET  = 16'd32637;
  localparam logic [15:0] GAIN_MAX    = 16'd32768;
  localparam logic [15:0] LEVEL_RESET = 16'd16384;
  localparam logic [15:0] LEVEL_MIN   = 16'd164;
  localparam logic [15:0] LEVEL_MAX   = 16'd32768;
  localparam logic [16:0] LEVEL_BASE  = 17'd1638;
  localparam logic [16:0] VEL_COEF    = 17'd91750;
  localparam logic [11:0] PERIOD_RESET = 12'd100;
  localparam logic [11:0] PERIOD_MIN   = 12'd2;

  // Multiplier bits consumed by the serial multiply, one per cycle
  localparam int unsigned MUL_BITS = 16;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_RD_A,
    ST_RD_B,
    ST_MUL_START,
    ST_MUL,
    ST_DONE
  } plsv_state_e;

  typedef struct packed {
    logic start;
    logic step;
  } plsv_mul_ctrl_t;

endpackage

### rtl/plsv_serial_mul.sv
// ---------------------------------------------------------------------------
// Plucked string voice serial multiplier
// Signed by unsigned shift-add multiply, one multiplier bit per cycle while step is set.
// ---------------------------------------------------------------------------
module plsv_serial_mul import plsv_pkg::*; #(
  parameter int unsigned MW = 16
) (
  input  logic                 clk_i,
  input  plsv_mul_ctrl_t       ctrl_i,
  input  logic signed [MW-1:0] mcand_i,
  input  logic [MUL_BITS-1:0]  mplier_i,
  output logic signed [MW:0]   prod_hi_o,
  output logic [MUL_BITS-1:0]  prod_lo_o
);

  logic signed [MW-1:0] mcand_q;
  logic [MUL_BITS-1:0]  mplier_q;
  logic signed [MW:0]   hi_q;
  logic [MUL_BITS-1:0]  lo_q;
  logic signed [MW+1:0] sum_w;

  // Add the selected partial product at the top, then shift one place right
  assign sum_w = $signed({hi_q[MW], hi_q}) +
                 (mplier_q[0] ? $signed({{2{mcand_q[MW-1]}}, mcand_q})
                              : $signed((MW+2)'(0)));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      hi_q     <= '0;
      lo_q     <= '0;
    end else if (ctrl_i.step) begin
      mplier_q <= {1'b0, mplier_q[MUL_BITS-1:1]};
      hi_q     <= sum_w[MW+1:1];
      lo_q     <= {sum_w[0], lo_q[MUL_BITS-1:1]};
    end
  end

  assign prod_hi_o = hi_q;
  assign prod_lo_o = lo_q;

endmodule

### rtl/plucked_string_synth_voice_unit.sv
// ---------------------------------------------------------------------------
// Plucked string synth voice
// One Karplus-Strong voice with a delay store and a serial multiply datapath.
// ---------------------------------------------------------------------------
// After reset the block sweeps the delay store to zero, one entry a cycle,
// and keeps in_stall_o high meanwhile; gain writes are taken during that
// time. A tick on a sounding voice makes two reads through the single
// read port of the store (states RD_A and RD_B), runs the serial
// multiplies (one multiplier bit per cycle), and then in a final state
// rounds, saturates and writes back. A tick on a silent voice goes
// straight to that final state. A note on makes one store write and one
// noise step per entry of the period. Note off and set period are done
// at transfer. The result sits in an output register, so the next item
// can be taken while a result is still stalled; a tick waits in its last
// cycle only when that register is still full.
`include "plucked_string_synth_voice_unit_defines.svh"

module plucked_string_synth_voice_unit import plsv_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // gain register
  input  logic               feedback_gain_we_i,
  input  logic [15:0]        feedback_gain_i,
  // item channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [11:0]        period_i,
  input  logic [15:0]        velocity_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_o,
  output logic               active_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam logic [AW:0] DEPTH_C   = (AW+1)'(STORE_DEPTH);
  localparam logic [16:0] DEPTH_17  = 17'(STORE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);
  localparam logic [AW-1:0] MUL_LAST  = AW'(MUL_BITS - 1);

  plsv_state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] period_q, period_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [15:0]   level_q, level_d;
  logic [15:0]   gain_q;
  logic          active_q, active_d;
  logic          live_q, live_d;
  logic [31:0]   lfsr_q, lfsr_d;
  logic [15:0]   a_q, a_d;
  logic          out_valid_q, out_valid_d;
  logic [15:0]   sample_q, sample_d;
  logic          out_active_q, out_active_d;

  // delay store
  logic [15:0]   mem_q [STORE_DEPTH];
  logic [15:0]   rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata;

  logic          in_xfer;
  logic          slot_free;
  logic [16:0]   per_clamp_w;
  logic [AW-1:0] per_new_w;
  logic [32:0]   vel_prod_w;
  logic [16:0]   lvl_raw_w;
  logic [15:0]   lvl_new_w;
  logic [AW-1:0] rd_new_w, pv_w, wp_inc_w;
  logic [31:0]   lfsr_nxt_w;
  logic [15:0]   noise_w;

  plsv_mul_ctrl_t       mul_ctrl;
  logic signed [16:0]   fb_mcand_w;
  logic signed [17:0]   fb_hi;
  logic [MUL_BITS-1:0]  fb_lo;
  logic signed [16:0]   lv_hi;
  logic [MUL_BITS-1:0]  lv_lo;
  logic signed [18:0]   fb_full_w;
  logic signed [19:0]   s_full_w;
  logic [15:0]          fb_sat_w, s_sat_w;
  logic                 quiet_w;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;

  // Clamp the period into 2 .. STORE_DEPTH-1
  always_comb begin
    if (period_i < PERIOD_MIN) begin
      per_clamp_w = 17'(PERIOD_MIN);
    end else if ({5'b0, period_i} >= DEPTH_17) begin
      per_clamp_w = DEPTH_17 - 17'd1;
    end else begin
      per_clamp_w = {5'b0, period_i};
    end
  end
  assign per_new_w = per_clamp_w[AW-1:0];

  // Pluck level: 0.1 + 1.4 * velocity in Q2.14, rounded
  assign vel_prod_w = {17'b0, velocity_i} * 33'(VEL_COEF);
  assign lvl_raw_w  = LEVEL_BASE + 17'((vel_prod_w + 33'(1 << 17)) >> 18);
  always_comb begin
    if (lvl_raw_w < 17'(LEVEL_MIN)) begin
      lvl_new_w = LEVEL_MIN;
    end else if (lvl_raw_w > 17'(LEVEL_MAX)) begin
      lvl_new_w = LEVEL_MAX;
    end else begin
      lvl_new_w = lvl_raw_w[15:0];
    end
  end

  // Pointer arithmetic, modulo the store depth
  always_comb begin
    if (wp_q >= period_q) begin
      rd_new_w = wp_q - period_q;
    end else begin
      rd_new_w = AW'({1'b0, wp_q} + DEPTH_C - {1'b0, period_q});
    end
  end
  assign pv_w     = (rd_q == '0) ? LAST_ADDR : rd_q - AW'(1);
  assign wp_inc_w = (({1'b0, wp_q} + (AW+1)'(1)) == DEPTH_C) ? '0 : wp_q + AW'(1);

  // Galois noise source; the entry is the top half with its sign bit flipped
  assign lfsr_nxt_w = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? LFSR_MASK : 32'h0);
  assign noise_w    = lfsr_nxt_w[31:16] ^ 16'h8000;

  // Serial multiplies: (a + b) * gain and a * level run side by side
  assign fb_mcand_w = $signed({a_q[15], a_q}) + $signed({rdata_q[15], rdata_q});

  plsv_serial_mul #(.MW(17)) u_fb_mul (
    .clk_i     (clk_i),
    .ctrl_i    (mul_ctrl),
    .mcand_i   (fb_mcand_w),
    .mplier_i  (gain_q),
    .prod_hi_o (fb_hi),
    .prod_lo_o (fb_lo)
  );

  plsv_serial_mul #(.MW(16)) u_lv_mul (
    .clk_i     (clk_i),
    .ctrl_i    (mul_ctrl),
    .mcand_i   ($signed(a_q)),
    .mplier_i  (level_q),
    .prod_hi_o (lv_hi),
    .prod_lo_o (lv_lo)
  );

  // Round to nearest (halves up) and saturate to Q1.15
  assign fb_full_w = $signed({fb_hi[17], fb_hi}) + $signed({18'b0, fb_lo[15]});
  assign s_full_w  = $signed({lv_hi[16], lv_hi, lv_lo[15:14]}) +
                     $signed({19'b0, lv_lo[13]});

  always_comb begin
    if (fb_full_w > 19'sd32767) begin
      fb_sat_w = 16'h7FFF;
    end else if (fb_full_w < -19'sd32768) begin
      fb_sat_w = 16'h8000;
    end else begin
      fb_sat_w = fb_full_w[15:0];
    end
    if (s_full_w > 20'sd32767) begin
      s_sat_w = 16'h7FFF;
    end else if (s_full_w < -20'sd32768) begin
      s_sat_w = 16'h8000;
    end else begin
      s_sat_w = s_full_w[15:0];
    end
  end
  assign quiet_w = ($signed(s_sat_w) >= -16'sd3) && ($signed(s_sat_w) <= 16'sd3);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    wp_d         = wp_q;
    period_d     = period_q;
    rd_d         = rd_q;
    level_d      = level_q;
    active_d     = active_q;
    live_d       = live_q;
    lfsr_d       = lfsr_q;
    a_d          = a_q;
    out_valid_d  = out_valid_q && out_stall_i;
    sample_d     = sample_q;
    out_active_d = out_active_q;
    mem_we       = 1'b0;
    mem_waddr    = cnt_q;
    mem_wdata    = 16'h0;
    mem_raddr    = rd_q;
    mul_ctrl     = '0;
    in_stall_o   = 1'b1;

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + AW'(1);
        if (cnt_q == LAST_ADDR) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_xfer) begin
          case (func_i)
            FUNC_TICK: begin
              live_d = active_q;
              rd_d   = rd_new_w;
              state_d = active_q ? ST_RD_A : ST_DONE;
            end
            FUNC_NOTE_ON: begin
              period_d = per_new_w;
              level_d  = lvl_new_w;
              cnt_d    = '0;
              state_d  = ST_FILL;
            end
            FUNC_NOTE_OFF: begin
              active_d = 1'b0;
            end
            FUNC_SET_PERIOD: begin
              period_d = per_new_w;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_FILL: begin
        // Write one noise entry per cycle, then start the voice
        mem_we    = 1'b1;
        mem_wdata = noise_w;
        lfsr_d    = lfsr_nxt_w;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == period_q - AW'(1)) begin
          cnt_d    = '0;
          wp_d     = period_q;
          active_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_RD_A: begin
        mem_raddr = rd_q;
        state_d   = ST_RD_B;
      end
      ST_RD_B: begin
        mem_raddr = pv_w;
        a_d       = rdata_q;
        state_d   = ST_MUL_START;
      end
      ST_MUL_START: begin
        mul_ctrl.start = 1'b1;
        cnt_d          = '0;
        state_d        = ST_MUL;
      end
      ST_MUL: begin
        mul_ctrl.step = 1'b1;
        cnt_d         = cnt_q + AW'(1);
        if (cnt_q == MUL_LAST) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold here until the output register can take the result
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (live_q) begin
            mem_we       = 1'b1;
            mem_waddr    = wp_q;
            mem_wdata    = fb_sat_w;
            wp_d         = wp_inc_w;
            sample_d     = s_sat_w;
            out_active_d = !quiet_w;
            if (quiet_w) begin
              active_d = 1'b0;
            end
          end else begin
            sample_d     = 16'h0;
            out_active_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      wp_q        <= '0;
      period_q    <= AW'(PERIOD_RESET);
      level_q     <= LEVEL_RESET;
      active_q    <= 1'b0;
      live_q      <= 1'b0;
      lfsr_q      <= LFSR_SEED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wp_q        <= wp_d;
      period_q    <= period_d;
      level_q     <= level_d;
      active_q    <= active_d;
      live_q      <= live_d;
      lfsr_q      <= lfsr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Gain register, saturated to 1.0 on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (feedback_gain_we_i) begin
      gain_q <= (feedback_gain_i > GAIN_MAX) ? GAIN_MAX : feedback_gain_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q         <= rd_d;
    a_q          <= a_d;
    sample_q     <= sample_d;
    out_active_q <= out_active_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = $signed(sample_q);
  assign active_o    = out_active_q;

  // A result only appears out of the final tick cycle
  `PLSV_ASSERT_NEXT(a_out_from_done, clk_i, rst_ni,
    (state_q != ST_DONE) && !out_valid_q, !out_valid_q)
  // The fill leaves the voice sounding with the pointer at the period
  `PLSV_ASSERT_NEXT(a_fill_end, clk_i, rst_ni,
    (state_q == ST_FILL) && (cnt_q == period_q - AW'(1)),
    active_q && (wp_q == $past(period_q)))
  // A tick on a silent voice gives a zero, inactive sample
  `PLSV_ASSERT_NEXT(a_silent_tick, clk_i, rst_ni,
    (state_q == ST_DONE) && !live_q && slot_free,
    out_valid_q && (sample_q == 16'h0) && !out_active_q)
  // Read pointer stays inside the store
  `PLSV_ASSERT_NOW(a_rd_range, clk_i, rst_ni,
    state_q == ST_RD_A, {1'b0, rd_q} < DEPTH_C)

endmodule
